@@ design/ppt_pkg.sv @@
// Shared types and constants for the pointer packet tracker.
package ppt_pkg;

   // Reset values of the limit registers and the cursor home position.
   localparam logic [15:0] LIMIT_X_RESET = 16'd1024;
   localparam logic [15:0] LIMIT_Y_RESET = 16'd768;
   localparam logic [15:0] CURSOR_X_HOME = 16'd320;
   localparam logic [15:0] CURSOR_Y_HOME = 16'd240;

   // Full-scale absolute coordinate and twice that, for the reciprocal fix-up.
   localparam logic [16:0] FULL_SCALE   = 17'd65535;
   localparam logic [16:0] FULL_SCALE_2 = 17'd131070;

   // Controller status and byte packet bits.
   localparam int STAT_DATA_BIT = 0;
   localparam int STAT_AUX_BIT  = 5;
   localparam int SYNC_BIT      = 3;

   // Absolute-pointer packet flag bits.
   localparam int FLAG_REL_BIT   = 16;
   localparam int FLAG_LEFT_BIT  = 5;
   localparam int FLAG_RIGHT_BIT = 4;
   localparam int FLAG_MID_BIT   = 3;

   typedef enum logic [1:0] {
      SRC_BYTE = 2'd0,
      SRC_REL  = 2'd1,
      SRC_ABS  = 2'd2
   } source_type;

   typedef enum logic [1:0] {
      CSR_LIMIT_X  = 2'd0,
      CSR_LIMIT_Y  = 2'd1,
      CSR_ABS_MODE = 2'd2
   } csr_index_type;

   // Position within a three-byte packet.
   typedef enum logic [1:0] {
      SLOT_HEAD = 2'd0,
      SLOT_DX   = 2'd1,
      SLOT_DY   = 2'd2
   } slot_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
   } limits_type;

   // Decoded event, after the first register.
   typedef struct packed {
      source_type         source;
      logic [2:0]         buttons;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [31:0]        prod_x;
      logic [31:0]        prod_y;
      logic               sat_x;
      logic               sat_y;
   } ev1_type;

   // Event ready for the cursor stage: either a move or an absolute target.
   typedef struct packed {
      logic               use_abs;
      source_type         source;
      logic [2:0]         buttons;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } ev2_type;

endpackage

@@ design/pointer_packet_tracker.sv @@
// Pointer packet tracker: cursor tracking from byte packets and absolute-pointer packets.
//
// Takes one request transaction per cycle while req_stall is low and gives at most one response
// transaction for it. The path is three register stages: decode (byte assembly, packet flags
// and the 16x16 coordinate multiply), scale (division by full scale as a shift-and-add with
// a small fix-up) and the cursor stage (add, clamp to the limit, event count), which also
// holds the response. Each stage moves on when the stage after it is empty or moving, so a
// waiting response does not stop earlier stages from filling. Requests that cause no event
// leave no bubble behind. Limits and mode are to be written through the csr port only while
// the block is idle; the block itself does not enforce this.

module pointer_packet_tracker #(
   parameter int POS_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [7:0]         req_ctrl_status,
   input  logic [7:0]         req_rx_byte,
   input  logic [31:0]        req_vm_flags,
   input  logic [31:0]        req_vm_x,
   input  logic [31:0]        req_vm_y,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_pos_x,
   output logic [15:0]        rsp_pos_y,
   output logic signed [16:0] rsp_move_x,
   output logic signed [16:0] rsp_move_y,
   output logic [2:0]         rsp_button_bits,
   output logic [31:0]        rsp_event_number,
   output logic [1:0]         rsp_source,
   // configuration
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // Largest position the cursor may hold; limits above it are cut down.
   localparam logic [15:0] LIM_CAP = (POS_WIDTH >= 16) ? 16'hffff :
                                     16'((32'd1 << POS_WIDTH) - 32'd1);
   localparam logic [15:0] LIM_X_RST = (ppt_pkg::LIMIT_X_RESET > LIM_CAP) ?
                                       LIM_CAP : ppt_pkg::LIMIT_X_RESET;
   localparam logic [15:0] LIM_Y_RST = (ppt_pkg::LIMIT_Y_RESET > LIM_CAP) ?
                                       LIM_CAP : ppt_pkg::LIMIT_Y_RESET;
   localparam logic [15:0] CUR_X_RST = (ppt_pkg::CURSOR_X_HOME > LIM_X_RST) ?
                                       LIM_X_RST : ppt_pkg::CURSOR_X_HOME;
   localparam logic [15:0] CUR_Y_RST = (ppt_pkg::CURSOR_Y_HOME > LIM_Y_RST) ?
                                       LIM_Y_RST : ppt_pkg::CURSOR_Y_HOME;

   logic [15:0]         limit_x_ff, limit_y_ff;
   logic                abs_mode_ff;
   ppt_pkg::limits_type limits;

   logic                ev1_valid, ev2_valid;
   ppt_pkg::ev1_type    ev1;
   ppt_pkg::ev2_type    ev2;
   logic                adv_cursor, adv_scale, adv_decode;
   logic                accept;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff  <= ppt_pkg::LIMIT_X_RESET;
         limit_y_ff  <= ppt_pkg::LIMIT_Y_RESET;
         abs_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ppt_pkg::CSR_LIMIT_X:  limit_x_ff  <= csr_wdata;
            ppt_pkg::CSR_LIMIT_Y:  limit_y_ff  <= csr_wdata;
            ppt_pkg::CSR_ABS_MODE: abs_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective limits, capped to the position width
   assign limits = {((limit_x_ff > LIM_CAP) ? LIM_CAP : limit_x_ff),
                    ((limit_y_ff > LIM_CAP) ? LIM_CAP : limit_y_ff)};

   // Flow control: a stage loads when it is empty or its contents move on
   assign adv_cursor = !rsp_valid || !rsp_stall;
   assign adv_scale  = !ev2_valid || adv_cursor;
   assign adv_decode = !ev1_valid || adv_scale;
   assign req_stall  = !adv_decode;
   assign accept     = req_valid && adv_decode;

   ppt_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .advance         (adv_decode),
      .abs_mode        (abs_mode_ff),
      .limits          (limits),
      .req_op          (req_op),
      .req_ctrl_status (req_ctrl_status),
      .req_rx_byte     (req_rx_byte),
      .req_vm_flags    (req_vm_flags),
      .req_vm_x        (req_vm_x),
      .req_vm_y        (req_vm_y),
      .ev1_valid       (ev1_valid),
      .ev1             (ev1)
   );

   ppt_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_scale),
      .limits    (limits),
      .ev1_valid (ev1_valid),
      .ev1       (ev1),
      .ev2_valid (ev2_valid),
      .ev2       (ev2)
   );

   ppt_cursor #(
      .CURSOR_X_RESET (CUR_X_RST),
      .CURSOR_Y_RESET (CUR_Y_RST)
   ) u_cursor (
      .clock            (clock),
      .reset            (reset),
      .load             (adv_cursor),
      .limits           (limits),
      .ev2_valid        (ev2_valid),
      .ev2              (ev2),
      .rsp_valid        (rsp_valid),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_button_bits  (rsp_button_bits),
      .rsp_event_number (rsp_event_number),
      .rsp_source       (rsp_source)
   );

endmodule

@@ design/ppt_decode.sv @@
// Byte packet assembly, packet flag decode and absolute-coordinate multiply.
module ppt_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                advance,
   input  logic                abs_mode,
   input  ppt_pkg::limits_type limits,
   input  logic                req_op,
   input  logic [7:0]          req_ctrl_status,
   input  logic [7:0]          req_rx_byte,
   input  logic [31:0]         req_vm_flags,
   input  logic [31:0]         req_vm_x,
   input  logic [31:0]         req_vm_y,
   output logic                ev1_valid,
   output ppt_pkg::ev1_type    ev1
);

   ppt_pkg::slot_type slot_ff, slot_in;
   logic [7:0]        first_byte_ff, first_byte_in;
   logic [7:0]        second_byte_ff, second_byte_in;
   logic              ev1_valid_ff;
   ppt_pkg::ev1_type  ev1_ff, ev1_in;
   logic              hit;
   logic              byte_ok;

   assign byte_ok = !req_op && req_ctrl_status[ppt_pkg::STAT_DATA_BIT]
                    && req_ctrl_status[ppt_pkg::STAT_AUX_BIT] && !abs_mode;

   always_comb begin
      slot_in        = slot_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      hit            = 1'b0;
      ev1_in         = '0;
      ev1_in.prod_x  = 32'(req_vm_x[15:0]) * 32'(limits.x);
      ev1_in.prod_y  = 32'(req_vm_y[15:0]) * 32'(limits.y);
      ev1_in.sat_x   = |req_vm_x[31:16];
      ev1_in.sat_y   = |req_vm_y[31:16];
      if (byte_ok) begin
         unique case (slot_ff)
            ppt_pkg::SLOT_HEAD: begin
               // drop bytes until one carries the sync bit
               if (req_rx_byte[ppt_pkg::SYNC_BIT]) begin
                  first_byte_in = req_rx_byte;
                  slot_in       = ppt_pkg::SLOT_DX;
               end
            end
            ppt_pkg::SLOT_DX: begin
               second_byte_in = req_rx_byte;
               slot_in        = ppt_pkg::SLOT_DY;
            end
            default: begin
               slot_in        = ppt_pkg::SLOT_HEAD;
               hit            = 1'b1;
               ev1_in.source  = ppt_pkg::SRC_BYTE;
               ev1_in.buttons = first_byte_ff[2:0];
               ev1_in.dx      = $signed({{25{second_byte_ff[7]}}, second_byte_ff});
               ev1_in.dy      = 33'sd0 - $signed({{25{req_rx_byte[7]}}, req_rx_byte});
            end
         endcase
      end else if (req_op && abs_mode) begin
         hit            = 1'b1;
         ev1_in.buttons = {req_vm_flags[ppt_pkg::FLAG_MID_BIT],
                           req_vm_flags[ppt_pkg::FLAG_RIGHT_BIT],
                           req_vm_flags[ppt_pkg::FLAG_LEFT_BIT]};
         if (req_vm_flags[ppt_pkg::FLAG_REL_BIT]) begin
            ev1_in.source = ppt_pkg::SRC_REL;
            ev1_in.dx     = $signed({req_vm_x[31], req_vm_x});
            ev1_in.dy     = 33'sd0 - $signed({req_vm_y[31], req_vm_y});
         end else begin
            ev1_in.source = ppt_pkg::SRC_ABS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= ppt_pkg::SLOT_HEAD;
         first_byte_ff  <= 8'd0;
         second_byte_ff <= 8'd0;
         ev1_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            slot_ff        <= slot_in;
            first_byte_ff  <= first_byte_in;
            second_byte_ff <= second_byte_in;
         end
         if (advance) begin
            ev1_valid_ff <= accept && hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ev1_ff <= ev1_in;
      end
   end

   assign ev1_valid = ev1_valid_ff;
   assign ev1       = ev1_ff;

endmodule

@@ design/ppt_scale.sv @@
// Division of the absolute-coordinate product by full scale, with saturation.
module ppt_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ppt_pkg::limits_type limits,
   input  logic                ev1_valid,
   input  ppt_pkg::ev1_type    ev1,
   output logic                ev2_valid,
   output ppt_pkg::ev2_type    ev2
);

   logic             ev2_valid_ff;
   ppt_pkg::ev2_type ev2_ff, ev2_in;
   logic [15:0]      abs_x, abs_y;

   // p / 65535 = hi + (hi + lo) / 65535, where the second term is 0, 1 or 2
   function automatic logic [15:0] div_full(input logic [31:0] prod);
      logic [16:0] t;
      logic [16:0] q;
      t = {1'b0, prod[31:16]} + {1'b0, prod[15:0]};
      q = {1'b0, prod[31:16]};
      if (t >= ppt_pkg::FULL_SCALE_2) begin
         q = q + 17'd2;
      end else if (t >= ppt_pkg::FULL_SCALE) begin
         q = q + 17'd1;
      end
      return q[15:0];
   endfunction

   // a coordinate above full scale lands on the limit
   assign abs_x = ev1.sat_x ? limits.x : div_full(ev1.prod_x);
   assign abs_y = ev1.sat_y ? limits.y : div_full(ev1.prod_y);

   always_comb begin
      ev2_in         = '0;
      ev2_in.source  = ev1.source;
      ev2_in.buttons = ev1.buttons;
      ev2_in.use_abs = (ev1.source == ppt_pkg::SRC_ABS);
      if (ev1.source == ppt_pkg::SRC_ABS) begin
         ev2_in.dx = $signed({17'd0, abs_x});
         ev2_in.dy = $signed({17'd0, abs_y});
      end else begin
         ev2_in.dx = ev1.dx;
         ev2_in.dy = ev1.dy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev2_valid_ff <= 1'b0;
      end else if (advance) begin
         ev2_valid_ff <= ev1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ev2_ff <= ev2_in;
      end
   end

   assign ev2_valid = ev2_valid_ff;
   assign ev2       = ev2_ff;

endmodule

@@ design/ppt_cursor.sv @@
// Cursor state, clamping, event count and the result register.
module ppt_cursor #(
   parameter logic [15:0] CURSOR_X_RESET = 16'd320,
   parameter logic [15:0] CURSOR_Y_RESET = 16'd240
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ppt_pkg::limits_type limits,
   input  logic                ev2_valid,
   input  ppt_pkg::ev2_type    ev2,
   output logic                rsp_valid,
   output logic [15:0]         rsp_pos_x,
   output logic [15:0]         rsp_pos_y,
   output logic signed [16:0]  rsp_move_x,
   output logic signed [16:0]  rsp_move_y,
   output logic [2:0]          rsp_button_bits,
   output logic [31:0]         rsp_event_number,
   output logic [1:0]          rsp_source
);

   logic [15:0]        cursor_x_ff, cursor_y_ff;
   logic [31:0]        event_total_ff, event_total_in;
   logic [15:0]        new_x, new_y;
   logic               rsp_valid_ff;
   logic [15:0]        pos_x_ff, pos_y_ff;
   logic signed [16:0] move_x_ff, move_y_ff;
   logic [2:0]         buttons_ff;
   logic [1:0]         source_ff;
   logic               step;

   function automatic logic [15:0] clamp(input logic [15:0] base,
                                         input logic signed [32:0] delta,
                                         input logic [15:0] lim);
      logic signed [33:0] sum;
      sum = $signed({18'd0, base}) + $signed({delta[32], delta});
      if (sum[33]) begin
         return 16'd0;
      end else if (sum > $signed({18'd0, lim})) begin
         return lim;
      end
      return sum[15:0];
   endfunction

   assign step           = load && ev2_valid;
   assign new_x          = clamp(ev2.use_abs ? 16'd0 : cursor_x_ff, ev2.dx, limits.x);
   assign new_y          = clamp(ev2.use_abs ? 16'd0 : cursor_y_ff, ev2.dy, limits.y);
   assign event_total_in = event_total_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff    <= CURSOR_X_RESET;
         cursor_y_ff    <= CURSOR_Y_RESET;
         event_total_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (step) begin
            cursor_x_ff    <= new_x;
            cursor_y_ff    <= new_y;
            event_total_ff <= event_total_in;
         end
         if (load) begin
            rsp_valid_ff <= ev2_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pos_x_ff   <= new_x;
         pos_y_ff   <= new_y;
         move_x_ff  <= $signed({1'b0, new_x} - {1'b0, cursor_x_ff});
         move_y_ff  <= $signed({1'b0, new_y} - {1'b0, cursor_y_ff});
         buttons_ff <= ev2.buttons;
         source_ff  <= ev2.source;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_move_x       = move_x_ff;
   assign rsp_move_y       = move_y_ff;
   assign rsp_button_bits  = buttons_ff;
   assign rsp_event_number = event_total_ff;
   assign rsp_source       = source_ff;

endmodule

@@ design/ppt_checker.sv @@
// Port-level checks for the pointer packet tracker, bound to the top level.
module ppt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_op,
   input logic [7:0]         req_ctrl_status,
   input logic [7:0]         req_rx_byte,
   input logic [31:0]        req_vm_flags,
   input logic [31:0]        req_vm_x,
   input logic [31:0]        req_vm_y,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_pos_x,
   input logic [15:0]        rsp_pos_y,
   input logic signed [16:0] rsp_move_x,
   input logic signed [16:0] rsp_move_y,
   input logic [2:0]         rsp_button_bits,
   input logic [31:0]        rsp_event_number,
   input logic [1:0]         rsp_source,
   input logic               csr_wr_en,
   input logic [1:0]         csr_index,
   input logic [15:0]        csr_wdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_number) && $stable(rsp_pos_x))
      else $error("stalled response changed");

   // consecutive responses count up by one
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=>
         !rsp_valid || rsp_event_number == $past(rsp_event_number) + 32'd1)
      else $error("event number not consecutive");

   // each move is the step from the previous response position
   a_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid ||
         (({1'b0, rsp_pos_x} - $unsigned(rsp_move_x)) == {1'b0, $past(rsp_pos_x)} &&
          ({1'b0, rsp_pos_y} - $unsigned(rsp_move_y)) == {1'b0, $past(rsp_pos_y)}))
      else $error("move does not match position step");

   // no response source beyond absolute
   a_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_source != 2'd3)
      else $error("bad response source");

endmodule

bind pointer_packet_tracker ppt_checker u_checker (.*);
